@@ rtl/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the 3D segment closest-approach pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

    // coordinate and difference widths
    localparam int CW   = 32;
    localparam int DW   = CW + 1;
    // 33x33 products and their three-term sums
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 1;
    localparam int MW   = PW;
    // limb split of the dot product magnitudes
    localparam int LB   = 22;
    localparam int NL   = MW / LB;
    localparam int PPW  = 2 * LB;
    localparam int QW   = 2 * MW;
    // signed and unsigned widths of denom, numa, numb
    localparam int SW   = QW + 2;
    localparam int UW   = SW - 1;
    // limb split for numb times a coordinate span
    localparam int NLB  = 23;
    localparam int NNL  = 6;
    localparam int NBW  = NLB * NNL;
    localparam int MLB  = 17;
    localparam int NML  = 2;
    localparam int MBW  = MLB * NML;
    localparam int PP2W = NLB + MLB;
    localparam int NW   = UW + DW;
    // quotient bits, one per divider stage
    localparam int QB   = DW;

    localparam int NDOT = 5;
    localparam int NPRD = 6;
    localparam int NDIV = QB;
    localparam int NPRE = 10;
    localparam int NSTG = NPRE + NDIV + 1;

    // difference vectors
    localparam int V13 = 0;
    localparam int V43 = 1;
    localparam int V21 = 2;

    // dot products
    localparam int D1343 = 0;
    localparam int D4321 = 1;
    localparam int D1321 = 2;
    localparam int D4343 = 3;
    localparam int D2121 = 4;

    localparam int DOT_A [NDOT] = '{V13, V43, V13, V43, V21};
    localparam int DOT_B [NDOT] = '{V43, V21, V21, V43, V21};

    // products: denom = p0 - p1, numa = p2 - p3, numb = p4 - p5
    localparam int PRD_A [NPRD] = '{D2121, D4321, D1343, D1321, D1343, D1321};
    localparam int PRD_B [NPRD] = '{D4343, D4321, D4321, D4343, D2121, D4321};

    typedef struct packed {
        logic signed [CW-1:0] a_start_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_start_z;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] a_end_z;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_start_z;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_end_y;
        logic signed [CW-1:0] b_end_z;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic                 degenerate;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } t_rsp;

    // per-item data that rides alongside the arithmetic
    typedef struct packed {
        logic [2:0][CW-1:0] b0;
        logic [2:0]         neg;
        logic [2:0][DW-1:0] mag;
    } t_side;

endpackage

@@ rtl/ssi_req_if.sv @@
// ----------------------------------------------------------------------------
// ssi_req_if
// Request channel: one pair of segments per request.
// ----------------------------------------------------------------------------
interface ssi_req_if;
    import ssi_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ssi_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ssi_rsp_if
// Response channel: hit and degenerate flags with the closest point.
// ----------------------------------------------------------------------------
interface ssi_rsp_if;
    import ssi_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/segment_segment_intersect_3d.sv @@
// ----------------------------------------------------------------------------
// segment_segment_intersect_3d
// Closest approach of two 3D segments in exact fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  i_req    | in  | a/b start and end points, Q16.16         | valid/ready
//  o_rsp    | out | hit, degenerate, point x/y/z, Q16.16     | valid/ready
//
//  one request enters per cycle while o_rsp is not stalled; the 33-stage
//  restoring divider forms each point coordinate one quotient bit a stage
//  reset (synchronous, active low) clears only the stage valid bits
//  a stall on o_rsp freezes every stage at once, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module segment_segment_intersect_3d (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ssi_req_if.sink         i_req,
    ssi_rsp_if.source       o_rsp
);
    import ssi_pkg::*;

    logic                en;
    logic [NSTG-1:0]     r_vld;

    // input decode
    logic signed [CW-1:0] c_a0 [3];
    logic signed [CW-1:0] c_a1 [3];
    logic signed [CW-1:0] c_b0 [3];
    logic signed [CW-1:0] c_b1 [3];
    logic signed [DW-1:0] c_v43 [3];
    t_side                c_sd;

    // stage registers
    t_side                r_sd  [NSTG-1];
    logic signed [DW-1:0] r1_v  [3][3];
    logic signed [PW-1:0] r2_p  [NDOT][3];
    logic signed [DOTW-1:0] r3_d [NDOT];
    logic [MW-1:0]        r4_m  [NDOT];
    logic                 r4_s  [NDOT];
    logic [PPW-1:0]       r5_pp [NPRD][NL][NL];
    logic                 r5_s  [NPRD];
    logic [QW-1:0]        c6_m  [NPRD];
    logic [QW-1:0]        r6_m  [NPRD];
    logic                 r6_s  [NPRD];
    logic signed [SW-1:0] c7_v  [NPRD];
    logic signed [SW-1:0] r7_dn;
    logic signed [SW-1:0] r7_na;
    logic signed [SW-1:0] r7_nb;
    logic signed [SW:0]   c8_ra;
    logic signed [SW:0]   c8_rb;
    logic                 c8_deg;
    logic                 r8_hit;
    logic                 r8_deg;
    logic [UW-1:0]        r8_nb;
    logic [UW-1:0]        r8_dn;
    logic [NBW-1:0]       c9_nb;
    logic [MBW-1:0]       c9_mg [3];
    logic [PP2W-1:0]      r9_pp [3][NNL][NML];
    logic                 r9_hit;
    logic                 r9_deg;
    logic [UW-1:0]        r9_dn;
    logic [NW-1:0]        c10_n [3];
    logic [NW-1:0]        r10_n [3];
    logic                 r10_hit;
    logic                 r10_deg;
    logic [UW-1:0]        r10_dn;

    // divider stages
    logic [UW-1:0]        s_rem [NDIV][3];
    logic [QB-1:0]        s_low [NDIV][3];
    logic [QB-1:0]        s_q   [NDIV][3];
    logic [UW-1:0]        s_dn  [NDIV];
    logic                 s_hit [NDIV];
    logic                 s_deg [NDIV];
    logic [UW-1:0]        c_rem [NDIV][3];
    logic [QB-1:0]        c_low [NDIV][3];
    logic [QB-1:0]        c_q   [NDIV][3];
    logic [UW-1:0]        r_rem [NDIV][3];
    logic [QB-1:0]        r_low [NDIV][3];
    logic [QB-1:0]        r_q   [NDIV][3];
    logic [UW-1:0]        r_dn  [NDIV];
    logic                 r_hit [NDIV];
    logic                 r_deg [NDIV];

    // output register
    t_rsp                 c_out;
    t_rsp                 r_out;

    // global advance: the whole pipe moves unless the last result is held
    assign en          = !r_vld[NSTG-1] || o_rsp.ready;
    assign i_req.ready = en;
    assign o_rsp.valid = r_vld[NSTG-1];
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_req.valid};
        end
    end

    // unpack request and side data
    always_comb begin
        c_a0[0] = i_req.data.a_start_x;
        c_a0[1] = i_req.data.a_start_y;
        c_a0[2] = i_req.data.a_start_z;
        c_a1[0] = i_req.data.a_end_x;
        c_a1[1] = i_req.data.a_end_y;
        c_a1[2] = i_req.data.a_end_z;
        c_b0[0] = i_req.data.b_start_x;
        c_b0[1] = i_req.data.b_start_y;
        c_b0[2] = i_req.data.b_start_z;
        c_b1[0] = i_req.data.b_end_x;
        c_b1[1] = i_req.data.b_end_y;
        c_b1[2] = i_req.data.b_end_z;
        for (int c = 0; c < 3; c++) begin
            c_v43[c]     = DW'(c_b1[c]) - DW'(c_b0[c]);
            c_sd.b0[c]   = c_b0[c];
            c_sd.neg[c]  = c_v43[c][DW-1];
            c_sd.mag[c]  = c_v43[c][DW-1] ? DW'(-c_v43[c]) : DW'(c_v43[c]);
        end
    end

    // side data shift line
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= c_sd;
            for (int k = 1; k < NSTG - 1; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // stage 1: difference vectors
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r1_v[V13][c] <= DW'(c_a0[c]) - DW'(c_b0[c]);
                r1_v[V43][c] <= c_v43[c];
                r1_v[V21][c] <= DW'(c_a1[c]) - DW'(c_a0[c]);
            end
        end
    end

    // stage 2: per-axis products of the dot products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < NDOT; d++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_p[d][c] <= PW'(r1_v[DOT_A[d]][c]) * PW'(r1_v[DOT_B[d]][c]);
                end
            end
        end
    end

    // stage 3: dot product sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < NDOT; d++) begin
                r3_d[d] <= DOTW'(r2_p[d][0]) + DOTW'(r2_p[d][1]) + DOTW'(r2_p[d][2]);
            end
        end
    end

    // stage 4: sign and magnitude
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < NDOT; d++) begin
                r4_s[d] <= r3_d[d][DOTW-1];
                r4_m[d] <= r3_d[d][DOTW-1] ? MW'(-r3_d[d]) : MW'(r3_d[d]);
            end
        end
    end

    // stage 5: limb partial products of the six wide products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NPRD; k++) begin
                r5_s[k] <= r4_s[PRD_A[k]] ^ r4_s[PRD_B[k]];
                for (int i = 0; i < NL; i++) begin
                    for (int j = 0; j < NL; j++) begin
                        r5_pp[k][i][j] <= PPW'(r4_m[PRD_A[k]][LB*i +: LB])
                                        * PPW'(r4_m[PRD_B[k]][LB*j +: LB]);
                    end
                end
            end
        end
    end

    // stage 6: recombine partial products
    always_comb begin
        for (int k = 0; k < NPRD; k++) begin
            c6_m[k] = '0;
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    c6_m[k] = c6_m[k] + (QW'(r5_pp[k][i][j]) << (LB * (i + j)));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_m <= c6_m;
            r6_s <= r5_s;
        end
    end

    // stage 7: denom, numa, numb
    always_comb begin
        for (int k = 0; k < NPRD; k++) begin
            c7_v[k] = r6_s[k] ? -$signed(SW'(r6_m[k])) : $signed(SW'(r6_m[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_dn <= c7_v[0] - c7_v[1];
            r7_na <= c7_v[2] - c7_v[3];
            r7_nb <= c7_v[4] - c7_v[5];
        end
    end

    // stage 8: degenerate and range tests
    assign c8_deg = r7_dn[SW-1] || (r7_dn == '0);
    assign c8_ra  = (SW+1)'(r7_dn) - (SW+1)'(r7_na);
    assign c8_rb  = (SW+1)'(r7_dn) - (SW+1)'(r7_nb);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_deg <= c8_deg;
            r8_hit <= !c8_deg && !r7_na[SW-1] && !r7_nb[SW-1]
                      && !c8_ra[SW] && !c8_rb[SW];
            r8_nb  <= r7_nb[UW-1:0];
            r8_dn  <= r7_dn[UW-1:0];
        end
    end

    // stage 9: numb times span magnitude, limb partial products
    assign c9_nb = NBW'(r8_nb);
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            c9_mg[c] = MBW'(r_sd[7].mag[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_hit <= r8_hit;
            r9_deg <= r8_deg;
            r9_dn  <= r8_dn;
            for (int c = 0; c < 3; c++) begin
                for (int i = 0; i < NNL; i++) begin
                    for (int j = 0; j < NML; j++) begin
                        r9_pp[c][i][j] <= PP2W'(c9_nb[NLB*i +: NLB])
                                        * PP2W'(c9_mg[c][MLB*j +: MLB]);
                    end
                end
            end
        end
    end

    // stage 10: dividend recombination
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            c10_n[c] = '0;
            for (int i = 0; i < NNL; i++) begin
                for (int j = 0; j < NML; j++) begin
                    c10_n[c] = c10_n[c]
                             + (NW'(r9_pp[c][i][j]) << (NLB * i + MLB * j));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_n   <= c10_n;
            r10_hit <= r9_hit;
            r10_deg <= r9_deg;
            r10_dn  <= r9_dn;
        end
    end

    // divider sources: the top bits of the dividend start below denom
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s_rem[0][c] = r10_n[c][NW-1:QB];
            s_low[0][c] = r10_n[c][QB-1:0];
            s_q[0][c]   = '0;
        end
        s_dn[0]  = r10_dn;
        s_hit[0] = r10_hit;
        s_deg[0] = r10_deg;
        for (int k = 1; k < NDIV; k++) begin
            s_rem[k] = r_rem[k-1];
            s_low[k] = r_low[k-1];
            s_q[k]   = r_q[k-1];
            s_dn[k]  = r_dn[k-1];
            s_hit[k] = r_hit[k-1];
            s_deg[k] = r_deg[k-1];
        end
    end

    // restoring division step, one quotient bit per stage
    always_comb begin
        logic [UW:0] t;
        logic [UW:0] diff;
        logic        ge;
        for (int k = 0; k < NDIV; k++) begin
            for (int c = 0; c < 3; c++) begin
                t    = {s_rem[k][c], s_low[k][c][QB-1]};
                diff = t - (UW+1)'(s_dn[k]);
                ge   = (t >= (UW+1)'(s_dn[k]));
                c_rem[k][c] = ge ? diff[UW-1:0] : t[UW-1:0];
                c_low[k][c] = {s_low[k][c][QB-2:0], 1'b0};
                c_q[k][c]   = {s_q[k][c][QB-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem <= c_rem;
            r_low <= c_low;
            r_q   <= c_q;
            r_dn  <= s_dn;
            r_hit <= s_hit;
            r_deg <= s_deg;
        end
    end

    // final point: offset from b start, toward b end
    always_comb begin
        logic [CW-1:0] off [3];
        logic [CW-1:0] pt  [3];
        for (int c = 0; c < 3; c++) begin
            off[c] = r_q[NDIV-1][c][CW-1:0];
            pt[c]  = r_sd[NSTG-2].neg[c] ? r_sd[NSTG-2].b0[c] - off[c]
                                         : r_sd[NSTG-2].b0[c] + off[c];
            if (!r_hit[NDIV-1]) begin
                pt[c] = '0;
            end
        end
        c_out.hit        = r_hit[NDIV-1];
        c_out.degenerate = r_deg[NDIV-1];
        c_out.point_x    = pt[0];
        c_out.point_y    = pt[1];
        c_out.point_z    = pt[2];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= c_out;
        end
    end

endmodule

@@ rtl/ssi_checker.sv @@
// ----------------------------------------------------------------------------
// ssi_checker
// Port-level checks on the segment closest-approach pipeline.
// ----------------------------------------------------------------------------
module ssi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_hit,
    input logic        i_deg,
    input logic [31:0] i_px,
    input logic [31:0] i_py,
    input logic [31:0] i_pz
);

    // a hit never comes with a degenerate pair
    a_hit_not_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit |-> !i_deg)
        else $error("hit reported on degenerate pair");

    // no hit gives a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> i_px == 32'd0 && i_py == 32'd0 && i_pz == 32'd0)
        else $error("point not zero without hit");

    // a held response keeps its content
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hit)
        && $stable(i_deg) && $stable(i_px) && $stable(i_py) && $stable(i_pz))
        else $error("held response changed");

    // a held response stalls the request side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("request taken while pipe is stalled");

    // reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

endmodule

bind segment_segment_intersect_3d ssi_checker u_ssi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_hit       (o_rsp.data.hit),
    .i_deg       (o_rsp.data.degenerate),
    .i_px        (o_rsp.data.point_x),
    .i_py        (o_rsp.data.point_y),
    .i_pz        (o_rsp.data.point_z)
);

@@ tb/tb_ssi_checker.sv @@
// ----------------------------------------------------------------------------
// tb_ssi_checker
// Watches the request and response channels of the segment closest-approach
// block, predicts each response in exact wide integer arithmetic and compares
// it with what the block returns, in order.
// ----------------------------------------------------------------------------
module tb_ssi_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ssi_req_if     i_req,
    ssi_rsp_if     i_rsp,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked,
    output int     o_hits,
    output int     o_degenerate
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssi_pkg::*;

    typedef logic signed [255:0] t_wide;

    t_rsp expected_rsp_q[$];

    // three-term dot product of two difference vectors
    function automatic t_wide dot3(t_wide a[3], t_wide b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // closest point on segment b, flags for hit and parallel/zero-length
    function automatic t_rsp closest_point(t_req r);
        t_wide a0[3], a1[3], b0[3], b1[3], v13[3], v43[3], v21[3], pt[3];
        t_wide d1343, d4321, d1321, d4343, d2121, denom, numa, numb, mag, off;
        logic [255:0] quo;
        t_rsp o;
        o = '0;
        a0[0] = $signed(r.a_start_x); a0[1] = $signed(r.a_start_y);
        a0[2] = $signed(r.a_start_z);
        a1[0] = $signed(r.a_end_x);   a1[1] = $signed(r.a_end_y);
        a1[2] = $signed(r.a_end_z);
        b0[0] = $signed(r.b_start_x); b0[1] = $signed(r.b_start_y);
        b0[2] = $signed(r.b_start_z);
        b1[0] = $signed(r.b_end_x);   b1[1] = $signed(r.b_end_y);
        b1[2] = $signed(r.b_end_z);
        for (int i = 0; i < 3; i++) begin
            v13[i] = a0[i] - b0[i];
            v43[i] = b1[i] - b0[i];
            v21[i] = a1[i] - a0[i];
            pt[i]  = '0;
        end
        d1343 = dot3(v13, v43);
        d4321 = dot3(v43, v21);
        d1321 = dot3(v13, v21);
        d4343 = dot3(v43, v43);
        d2121 = dot3(v21, v21);
        denom = d2121 * d4343 - d4321 * d4321;
        numa  = d1343 * d4321 - d1321 * d4343;
        numb  = d1343 * d2121 - d1321 * d4321;
        // parallel or zero-length segments
        if (denom <= 0) begin
            o.degenerate = 1'b1;
            return o;
        end
        if (numa < 0 || numb < 0 || numa > denom || numb > denom)
            return o;
        // offset truncated toward b_start
        o.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            mag = (v43[i] < 0) ? -v43[i] : v43[i];
            quo = $unsigned(numb * mag) / $unsigned(denom);
            off = $signed(quo & 256'hF_FFFF_FFFF);
            pt[i] = (v43[i] < 0) ? b0[i] - off : b0[i] + off;
        end
        o.point_x = pt[0][CW-1:0];
        o.point_y = pt[1][CW-1:0];
        o.point_z = pt[2][CW-1:0];
        return o;
    endfunction

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_hits       = 0;
        o_degenerate = 0;
    end

    assign o_pending = expected_rsp_q.size();

    // predict on accepted requests, compare on accepted responses
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready)
                expected_rsp_q.push_back(closest_point(i_req.data));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected response %p", i_rsp.data);
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    o_checked <= o_checked + 1;
                    o_hits <= o_hits + exp_rsp.hit;
                    o_degenerate <= o_degenerate + exp_rsp.degenerate;
                    if (i_rsp.data.hit !== exp_rsp.hit
                        || i_rsp.data.degenerate !== exp_rsp.degenerate
                        || i_rsp.data.point_x !== exp_rsp.point_x
                        || i_rsp.data.point_y !== exp_rsp.point_y
                        || i_rsp.data.point_z !== exp_rsp.point_z) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p, got %p",
                                     exp_rsp, i_rsp.data);
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb_segment_segment_intersect_3d.sv @@
// ----------------------------------------------------------------------------
// tb_segment_segment_intersect_3d
// Drives directed and random segment pairs into the closest-approach block
// with random idling on both channels; a checker alongside scores responses.
// ----------------------------------------------------------------------------
module tb_segment_segment_intersect_3d;
    timeunit 1ns;
    timeprecision 1ps;
    import ssi_pkg::*;

    localparam int N_RANDOM  = 600;
    localparam int N_CALM    = 100;
    localparam int MAX_CYCLE = 300000;
    localparam int ONE       = 65536;

    logic i_clk;
    logic i_rst_n;
    logic idle_on;
    int   stall_left;
    int   cycle_count;
    int   fail_count, pending, checked, hits, degen;

    ssi_req_if req_if ();
    ssi_rsp_if rsp_if ();

    segment_segment_intersect_3d dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    tb_ssi_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_degenerate (degen)
    );

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        idle_on       = 1'b1;
        stall_left    = 0;
        cycle_count   = 0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout with %0d responses outstanding", pending);
            $display("tb_segment_segment_intersect_3d: errors");
            $finish;
        end
    end

    // response back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 14);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // one request, with an occasional idle burst in front of it
    task automatic send_pair(t_req r);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    function automatic t_req make_pair(int ax0, int ay0, int az0, int ax1, int ay1,
                                       int az1, int bx0, int by0, int bz0, int bx1,
                                       int by1, int bz1);
        t_req r;
        r = '{ax0, ay0, az0, ax1, ay1, az1, bx0, by0, bz0, bx1, by1, bz1};
        return r;
    endfunction

    function automatic int small_coord(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // random pair: half crossing segments, some parallel, rest noise
    function automatic t_req random_pair();
        t_req r;
        int   span, mx, my, mz, ex, ey, ez, dx, dy, dz;
        int   kind;
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(4, 26);
        if (kind < 5) begin
            // b crosses a near its midpoint
            r.a_start_x = small_coord(span); r.a_start_y = small_coord(span);
            r.a_start_z = small_coord(span); r.a_end_x = small_coord(span);
            r.a_end_y = small_coord(span);   r.a_end_z = small_coord(span);
            mx = (r.a_start_x + r.a_end_x) >>> 1;
            my = (r.a_start_y + r.a_end_y) >>> 1;
            mz = (r.a_start_z + r.a_end_z) >>> 1;
            ex = small_coord(span); ey = small_coord(span); ez = small_coord(span);
            r.b_start_x = mx - ex; r.b_start_y = my - ey; r.b_start_z = mz - ez;
            r.b_end_x = mx + ex;   r.b_end_y = my + ey;   r.b_end_z = mz + ez;
        end else if (kind < 6) begin
            // parallel copy of a, or a zero-length b
            r.a_start_x = small_coord(span); r.a_start_y = small_coord(span);
            r.a_start_z = small_coord(span); r.a_end_x = small_coord(span);
            r.a_end_y = small_coord(span);   r.a_end_z = small_coord(span);
            dx = small_coord(span); dy = small_coord(span); dz = small_coord(span);
            r.b_start_x = r.a_start_x + dx; r.b_start_y = r.a_start_y + dy;
            r.b_start_z = r.a_start_z + dz;
            if ($urandom_range(0, 1)) begin
                r.b_end_x = r.a_end_x + dx; r.b_end_y = r.a_end_y + dy;
                r.b_end_z = r.a_end_z + dz;
            end else begin
                r.b_end_x = r.b_start_x; r.b_end_y = r.b_start_y;
                r.b_end_z = r.b_start_z;
            end
        end else if (kind < 8) begin
            r = make_pair(small_coord(span), small_coord(span), small_coord(span),
                          small_coord(span), small_coord(span), small_coord(span),
                          small_coord(span), small_coord(span), small_coord(span),
                          small_coord(span), small_coord(span), small_coord(span));
        end else begin
            // full-range noise
            r = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        return r;
    endfunction

    initial begin
        t_req directed_q[$];
        int   mn, mx;
        mn = 32'sh8000_0000;
        mx = 32'sh7fff_ffff;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all zero: both segments of zero length
        directed_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // clean crossing in the xy plane
        directed_q.push_back(make_pair(0, 0, 0, 2*ONE, 2*ONE, 0,
                                       0, 2*ONE, 0, 2*ONE, 0, 0));
        // b running the negative way on every axis
        directed_q.push_back(make_pair(-ONE, ONE, -ONE, ONE, -ONE, ONE,
                                       ONE, ONE, ONE, -ONE, -ONE, -ONE));
        // skew lines crossing within both spans
        directed_q.push_back(make_pair(0, 0, 0, 4*ONE, 0, 0,
                                       ONE, -ONE, ONE, ONE, ONE, ONE));
        // closest approach beyond the end of a
        directed_q.push_back(make_pair(0, 0, 0, ONE, 0, 0,
                                       3*ONE, -ONE, 0, 3*ONE, ONE, 0));
        // closest approach before the start of b
        directed_q.push_back(make_pair(0, 0, 0, 2*ONE, 0, 0,
                                       ONE, ONE, 0, ONE, 3*ONE, 0));
        // touching at endpoints: parameters exactly zero and one
        directed_q.push_back(make_pair(0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE, ONE, 0));
        directed_q.push_back(make_pair(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0, ONE));
        // parallel segments
        directed_q.push_back(make_pair(0, 0, 0, ONE, ONE, ONE,
                                       ONE, 0, 0, 2*ONE, ONE, ONE));
        // collinear segments
        directed_q.push_back(make_pair(0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0, 3*ONE, 0, 0));
        // zero-length a, then zero-length b
        directed_q.push_back(make_pair(ONE, ONE, ONE, ONE, ONE, ONE,
                                       0, 0, 0, ONE, 0, 0));
        directed_q.push_back(make_pair(0, 0, 0, ONE, 0, 0, ONE, ONE, 0, ONE, ONE, 0));
        // full-range extremes
        directed_q.push_back(make_pair(mn, mn, mn, mx, mx, mx, mn, mx, mn, mx, mn, mx));
        directed_q.push_back(make_pair(mx, mn, 0, mn, mx, 0, mn, mn, 0, mx, mx, 0));
        directed_q.push_back(make_pair(mn, 0, mx, mx, 0, mn, 0, mn, mn, 0, mx, mx));
        directed_q.push_back(make_pair(mx, mx, mx, mx, mx, mx, mn, mn, mn, mn, mn, mn));
        directed_q.push_back(make_pair(mn, mn, mn, mn, mn, mx, mx, mx, mn, mx, mn, mn));
        // segments of one and two ulps per axis
        directed_q.push_back(make_pair(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0));
        directed_q.push_back(make_pair(-1, -1, 0, 1, 1, 0, -1, 1, 0, 1, -1, 0));

        foreach (directed_q[i]) send_pair(directed_q[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - N_CALM) idle_on = 1'b0;
            send_pair(random_pair());
        end
        req_if.valid <= 1'b0;

        // drain
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("%0d segment pairs checked: %0d crossing, %0d parallel or zero-length",
                 checked, hits, degen);
        $display("directed extremes plus random crossings, parallels and noise");
        if (fail_count == 0)
            $display("tb_segment_segment_intersect_3d: clean");
        else
            $display("tb_segment_segment_intersect_3d: errors");
        $finish;
    end

endmodule
